// ===== src/rrm_pkg.sv =====
// ----------------------------------------------------------------------------
// rrm_pkg: shared types and constants for the rounded RGB mean core
// Pixel and result word layouts, default count width, queue depth.
// ----------------------------------------------------------------------------
package rrm_pkg;

	// default width of the included-pixel count
	localparam int COUNT_BITS_DEF = 16;

	// region records waiting between accumulator and divider (power of two)
	localparam int QUEUE_DEPTH = 2;

	// quotient bits per channel mean
	localparam int MEAN_BITS = 8;

	// width of the reported pixel total
	localparam int TOTAL_BITS = 16;

	// one input word: a pixel with its mask and end-of-region flags
	typedef struct packed {
		logic [7:0] chan0;
		logic [7:0] chan1;
		logic [7:0] chan2;
		logic       include_req;
		logic       region_end;
	} pixel_t;

	// one result word: per-channel rounded means and region status
	typedef struct packed {
		logic [MEAN_BITS-1:0]  mean0;
		logic [MEAN_BITS-1:0]  mean1;
		logic [MEAN_BITS-1:0]  mean2;
		logic [TOTAL_BITS-1:0] pixel_total;
		logic                  overflow;
	} result_t;

endpackage

// ===== src/rrm_front.sv =====
// ----------------------------------------------------------------------------
// rrm_front: pixel accumulator
// Adds included pixels into three channel sums and a saturating count, and
// hands the region totals on when the end-of-region pixel arrives.
// ----------------------------------------------------------------------------
module rrm_front #(
	parameter int COUNT_BITS = rrm_pkg::COUNT_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  rrm_pkg::pixel_t         pixel,
	output logic                    push,
	output logic [COUNT_BITS+7:0]   push_sum0,
	output logic [COUNT_BITS+7:0]   push_sum1,
	output logic [COUNT_BITS+7:0]   push_sum2,
	output logic [COUNT_BITS-1:0]   push_count,
	output logic                    push_sat
);

	localparam int SUM_BITS = COUNT_BITS + 8;

	logic [SUM_BITS-1:0]   sum0_q, sum1_q, sum2_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  sat_q;

	logic [SUM_BITS-1:0]   sum0_nx, sum1_nx, sum2_nx;
	logic [COUNT_BITS-1:0] count_nx;
	logic                  sat_nx;
	logic                  at_limit;

	// totals including the current pixel
	always_comb begin
		at_limit = &count_q;
		sum0_nx  = sum0_q;
		sum1_nx  = sum1_q;
		sum2_nx  = sum2_q;
		count_nx = count_q;
		sat_nx   = sat_q;
		if (pixel.include_req) begin
			if (!at_limit) begin
				sum0_nx  = sum0_q + SUM_BITS'(pixel.chan0);
				sum1_nx  = sum1_q + SUM_BITS'(pixel.chan1);
				sum2_nx  = sum2_q + SUM_BITS'(pixel.chan2);
				count_nx = count_q + COUNT_BITS'(1);
			end else begin
				sat_nx = 1'b1;
			end
		end
	end

	// hand-off of the finished region
	assign push       = accept && pixel.region_end;
	assign push_sum0  = sum0_nx;
	assign push_sum1  = sum1_nx;
	assign push_sum2  = sum2_nx;
	assign push_count = count_nx;
	assign push_sat   = sat_nx;

	// running totals, cleared after each region
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum0_q  <= '0;
			sum1_q  <= '0;
			sum2_q  <= '0;
			count_q <= '0;
			sat_q   <= 1'b0;
		end else if (accept) begin
			if (pixel.region_end) begin
				sum0_q  <= '0;
				sum1_q  <= '0;
				sum2_q  <= '0;
				count_q <= '0;
				sat_q   <= 1'b0;
			end else begin
				sum0_q  <= sum0_nx;
				sum1_q  <= sum1_nx;
				sum2_q  <= sum2_nx;
				count_q <= count_nx;
				sat_q   <= sat_nx;
			end
		end
	end

endmodule

// ===== src/rrm_queue.sv =====
// ----------------------------------------------------------------------------
// rrm_queue: region record queue
// Small FIFO between accumulator and divider; first-word read is direct.
// ----------------------------------------------------------------------------
module rrm_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = rrm_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty,
	output logic             full
);

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]    mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0] fill_q;

	assign empty = (fill_q == '0);
	assign full  = (fill_q == CNT_BITS'(DEPTH));
	assign rdata = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_BITS'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + CNT_BITS'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - CNT_BITS'(1);
			end
		end
	end

endmodule

// ===== src/rrm_back.sv =====
// ----------------------------------------------------------------------------
// rrm_back: rounded mean divider
// Three restoring-division lanes, one quotient bit per cycle, computing
// (sum + count/2) / count for each channel of a queued region record.
// ----------------------------------------------------------------------------
module rrm_back #(
	parameter int COUNT_BITS = rrm_pkg::COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  avail,
	input  logic [COUNT_BITS+7:0] rec_sum0,
	input  logic [COUNT_BITS+7:0] rec_sum1,
	input  logic [COUNT_BITS+7:0] rec_sum2,
	input  logic [COUNT_BITS-1:0] rec_count,
	input  logic                  rec_sat,
	output logic                  pop,
	output rrm_pkg::result_t      result,
	output logic                  result_valid
);

	localparam int SUM_BITS  = COUNT_BITS + 8;
	localparam int MB        = rrm_pkg::MEAN_BITS;
	localparam int STEP_BITS = $clog2(MB);
	localparam int EXT_BITS  = 32;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t                      state_q;
	logic [STEP_BITS-1:0]        step_q;
	logic [2:0][SUM_BITS-1:0]    rem_q;
	logic [2:0][MB-1:0]          quo_q;
	logic [SUM_BITS-1:0]         div_q;
	logic [COUNT_BITS-1:0]       n_q;
	logic                        sat_q;

	logic [2:0][SUM_BITS-1:0]    sums;
	logic [2:0]                  ge;
	logic [2:0][MB-1:0]          quo_nx;
	logic [SUM_BITS-1:0]         half_n;
	logic                        n_zero;
	logic [EXT_BITS-1:0]         n_ext;

	assign sums   = {rec_sum2, rec_sum1, rec_sum0};
	assign half_n = SUM_BITS'(rec_count >> 1);
	assign pop    = (state_q == ST_IDLE) && avail;
	assign n_zero = (n_q == '0);
	assign n_ext  = EXT_BITS'(n_q);

	// trial subtract in each lane
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ge[k]     = (rem_q[k] >= div_q);
			quo_nx[k] = {quo_q[k][MB-2:0], ge[k]};
		end
	end

	// division datapath
	always_ff @(posedge clk) begin
		if (pop) begin
			for (int k = 0; k < 3; k++) begin
				rem_q[k] <= sums[k] + half_n;
				quo_q[k] <= '0;
			end
			div_q <= SUM_BITS'(rec_count) << (MB - 1);
			n_q   <= rec_count;
			sat_q <= rec_sat;
		end else if (state_q == ST_RUN) begin
			for (int k = 0; k < 3; k++) begin
				if (ge[k]) begin
					rem_q[k] <= rem_q[k] - div_q;
				end
				quo_q[k] <= quo_nx[k];
			end
			div_q <= div_q >> 1;
		end
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_q       <= '0;
			result       <= '0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (avail) begin
						step_q  <= STEP_BITS'(MB - 1);
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (step_q == '0) begin
						// empty region reports zero means
						result.mean0       <= n_zero ? '0 : quo_nx[0];
						result.mean1       <= n_zero ? '0 : quo_nx[1];
						result.mean2       <= n_zero ? '0 : quo_nx[2];
						result.pixel_total <= n_ext[rrm_pkg::TOTAL_BITS-1:0];
						result.overflow    <= sat_q;
						result_valid       <= 1'b1;
						state_q            <= ST_IDLE;
					end else begin
						step_q <= step_q - STEP_BITS'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== src/rounded_rgb_mean_core.sv =====
// ----------------------------------------------------------------------------
// rounded_rgb_mean_core: rounded per-channel mean of a pixel region
// Accumulator front end, region queue, and bit-serial divider back end.
// ----------------------------------------------------------------------------
// Pixels are taken one word per cycle whenever busy is low; included pixels
// add into three channel sums and a count that saturates at 2^COUNT_BITS-1
// (further included pixels set the overflow flag). The pixel flagged with
// region_end closes the region: its totals go into a two-entry queue and the
// divider, once it takes them, produces one result word, shown for exactly
// one cycle with result_valid high. The receiver cannot stall, so the result
// must be captured on that cycle. Each region occupies the divider for one
// load step and eight quotient-bit steps (all three channels in parallel);
// busy rises only when two closed regions are still waiting, which happens
// when regions shorter than about nine pixels arrive in a row.
// ----------------------------------------------------------------------------
module rounded_rgb_mean_core #(
	parameter int COUNT_BITS = rrm_pkg::COUNT_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  rrm_pkg::pixel_t  pixel,
	output rrm_pkg::result_t result,
	output logic             result_valid
);

	localparam int SUM_BITS = COUNT_BITS + 8;
	localparam int REC_BITS = 3 * SUM_BITS + COUNT_BITS + 1;
	localparam logic [31:0] LIMIT_EXT = 32'((64'(1) << COUNT_BITS) - 64'(1));

	logic                  accept;
	logic                  q_push, q_pop, q_empty, q_full;
	logic [REC_BITS-1:0]   q_wdata, q_rdata;
	logic [SUM_BITS-1:0]   f_sum0, f_sum1, f_sum2;
	logic [COUNT_BITS-1:0] f_count;
	logic                  f_sat;
	logic [SUM_BITS-1:0]   b_sum0, b_sum1, b_sum2;
	logic [COUNT_BITS-1:0] b_count;
	logic                  b_sat;

	// input word handshake
	assign busy   = q_full;
	assign accept = start && !busy;

	rrm_front #(
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.pixel     (pixel),
		.push      (q_push),
		.push_sum0 (f_sum0),
		.push_sum1 (f_sum1),
		.push_sum2 (f_sum2),
		.push_count(f_count),
		.push_sat  (f_sat)
	);

	// region record packing
	assign q_wdata = {f_sat, f_count, f_sum2, f_sum1, f_sum0};
	assign {b_sat, b_count, b_sum2, b_sum1, b_sum0} = q_rdata;

	rrm_queue #(
		.WIDTH(REC_BITS),
		.DEPTH(rrm_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.pop   (q_pop),
		.rdata (q_rdata),
		.empty (q_empty),
		.full  (q_full)
	);

	rrm_back #(
		.COUNT_BITS(COUNT_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.avail       (!q_empty),
		.rec_sum0    (b_sum0),
		.rec_sum1    (b_sum1),
		.rec_sum2    (b_sum2),
		.rec_count   (b_count),
		.rec_sat     (b_sat),
		.pop         (q_pop),
		.result      (result),
		.result_valid(result_valid)
	);

	// a closed region never lands in a full queue
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("region record pushed into full queue");

	// the divider never emits results on consecutive cycles
	a_result_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe held for more than one cycle");

	// overflow is only reported with the count at its limit
	a_overflow_total: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.overflow) |->
		(result.pixel_total == LIMIT_EXT[rrm_pkg::TOTAL_BITS-1:0]))
		else $error("overflow reported below count limit");

	// nothing pops from an empty queue
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("divider took a record from an empty queue");

endmodule
